[rtl/ttl_bucket_timer_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// TTL bucket timer engine assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef TTL_BUCKET_TIMER_ENGINE_UNIT_MACROS_SVH
`define TTL_BUCKET_TIMER_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TTLB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ttlb_pkg.sv]
// ----------------------------------------------------------------------------
// ttlb_pkg
// Sizes, codes, table entry layouts and sequencer states of the timer engine.
// ----------------------------------------------------------------------------
package ttlb_pkg;

  localparam int TIMER_SLOTS = 64;
  localparam int CLASS_SLOTS = 16;
  localparam int TIME_BITS   = 64;
  localparam int TW          = $clog2(TIMER_SLOTS);
  localparam int CW          = $clog2(CLASS_SLOTS);
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

  localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

  typedef logic [TW:0]          tptr_t;   // top bit set: null
  typedef logic [CW:0]          cptr_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [TIME_BITS:0]   time_x_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam tptr_t T_NIL    = tptr_t'(TIMER_SLOTS);
  localparam cptr_t C_NIL    = cptr_t'(CLASS_SLOTS);
  localparam time_t TIME_MAX = '1;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_DEL  = 3'd1,
    MODE_TICK = 3'd2,
    MODE_ADV  = 3'd3,
    MODE_SET  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  typedef struct packed {
    time_t            expiry;
    tptr_t            prev;
    tptr_t            next;
    logic [CW-1:0]    cls;
  } timer_ent_t;

  typedef struct packed {
    logic [31:0] ttl;
    tptr_t       head;
    tptr_t       tail;
    cptr_t       prev;
    cptr_t       next;
  } class_ent_t;

  typedef struct packed {
    logic          we;
    logic [TW-1:0] waddr;
    timer_ent_t    wdata;
    logic [TW-1:0] raddr;
  } tmem_req_t;

  typedef struct packed {
    logic          we;
    logic [CW-1:0] waddr;
    class_ent_t    wdata;
    logic [CW-1:0] raddr;
  } cmem_req_t;

  typedef struct packed {
    logic          we;
    logic [TW-1:0] waddr;
    logic [TW-1:0] wdata;
    logic [TW-1:0] raddr;
  } fmem_req_t;

  typedef struct packed {
    logic          fired;
    logic [TW-1:0] fired_id;
    logic          last;
    status_t       status;
    cnt_t          live_count;
    time_t         next_expiry;
    time_t         current_time;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_HASH,
    S_PROBE,
    S_PROBE_C,
    S_ADD_W1,
    S_ADD_W2,
    S_DEL_T,
    S_DEL_C,
    S_DEL_N,
    S_UL_P,
    S_UL_N,
    S_CL_START,
    S_CL_CRD,
    S_CL_C,
    S_CL_T,
    S_CL_DONE,
    S_CL_END,
    S_EM_RD,
    S_EM_W
  } state_t;

endpackage

[rtl/ttlb_ifs.sv]
// ----------------------------------------------------------------------------
// ttlb channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ttlb_in_if;
  import ttlb_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [TW-1:0]     timer_id;
  logic [31:0]       ttl;
  time_t             new_time;
  modport source (output valid, mode, timer_id, ttl, new_time, input ready);
  modport sink   (input valid, mode, timer_id, ttl, new_time, output ready);
endinterface

interface ttlb_out_if;
  import ttlb_pkg::*;
  logic              valid;
  logic              ready;
  logic              fired;
  logic [TW-1:0]     fired_id;
  logic              last;
  logic [1:0]        status;
  cnt_t              live_count;
  time_t             next_expiry;
  time_t             current_time;
  modport source (output valid, fired, fired_id, last, status, live_count, next_expiry,
                  current_time, input ready);
  modport sink   (input valid, fired, fired_id, last, status, live_count, next_expiry,
                  current_time, output ready);
endinterface

[rtl/ttlb_ram.sv]
// ----------------------------------------------------------------------------
// ttlb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ttlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ttlb_hash.sv]
// ----------------------------------------------------------------------------
// ttlb_hash
// Golden-ratio probe start: top bits of ttl * HASH_MULT mod 2^64, two stages.
// ----------------------------------------------------------------------------
module ttlb_hash (
  input  logic                    clk,
  input  logic [31:0]             ttl,
  output logic [ttlb_pkg::CW-1:0] start
);
  import ttlb_pkg::*;

  logic [63:0] lo_prod;
  logic [63:0] hi_prod;
  logic [31:0] lo_hi;
  logic [31:0] hi_lo;
  logic [31:0] sum;

  // bits 63:32 of the 64-bit product come from two 32x32 partial products
  assign lo_prod = {32'd0, ttl} * {32'd0, HASH_MULT[31:0]};
  assign hi_prod = {32'd0, ttl} * {32'd0, HASH_MULT[63:32]};

  always_ff @(posedge clk) begin
    lo_hi <= lo_prod[63:32];
    hi_lo <= hi_prod[31:0];
  end

  assign sum   = lo_hi + hi_lo;
  assign start = sum[31 -: CW];

endmodule

[rtl/ttlb_ctrl.sv]
// ----------------------------------------------------------------------------
// ttlb_ctrl
// Command sequencer: class probe, queue append/remove, live-list walk, emit.
// ----------------------------------------------------------------------------
module ttlb_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_mode,
  input  logic [ttlb_pkg::TW-1:0] in_id,
  input  logic [31:0]             in_ttl,
  input  ttlb_pkg::time_t         in_time,
  output logic [31:0]             hash_ttl,
  input  logic [ttlb_pkg::CW-1:0] hash_start,
  output ttlb_pkg::tmem_req_t     treq,
  input  ttlb_pkg::timer_ent_t    trd,
  output ttlb_pkg::cmem_req_t     creq,
  input  ttlb_pkg::class_ent_t    crd,
  output ttlb_pkg::fmem_req_t     freq,
  input  logic [ttlb_pkg::TW-1:0] frd,
  input  logic                    res_free,
  output logic                    res_load,
  output ttlb_pkg::res_t          res
);
  import ttlb_pkg::*;

  state_t                 state, state_next;
  mode_t                  mode_q;
  logic [TW-1:0]          id_q;
  logic [31:0]            ttl_q;
  time_t                  time_q;
  status_t                status_q;
  time_t                  cur_time;
  cnt_t                   live_total;
  time_t                  bound;
  cptr_t                  lst_head;
  logic [CLASS_SLOTS-1:0] class_valid;
  logic [TIMER_SLOTS-1:0] stored;
  logic [CW-1:0]          pidx;
  logic [CW-1:0]          pk;
  class_ent_t             cq;
  timer_ent_t             tq;
  cptr_t                  ul_pr;
  cptr_t                  ul_nx;
  state_t                 ul_ret;
  cptr_t                  cc;
  time_t                  ne;
  cnt_t                   nf;
  cnt_t                   k;

  time_x_t    add_sum;
  time_t      add_exp;
  class_ent_t add_cls;
  tptr_t      del_head;
  tptr_t      del_tail;
  logic       pop;
  logic       em_last;

  assign hash_ttl = ttl_q;
  assign in_ready = (state == S_IDLE);

  // saturating expiry
  assign add_sum = {1'b0, cur_time} + time_x_t'(ttl_q);
  assign add_exp = add_sum[TIME_BITS] ? TIME_MAX : add_sum[TIME_BITS-1:0];

  always_comb begin
    add_cls      = cq;
    add_cls.head = (cq.tail == T_NIL) ? {1'b0, id_q} : cq.head;
    add_cls.tail = {1'b0, id_q};
    if (cq.head == T_NIL) begin
      add_cls.prev = C_NIL;
      add_cls.next = lst_head;
    end
  end

  assign del_head = (tq.prev == T_NIL) ? tq.next : cq.head;
  assign del_tail = (tq.next == T_NIL) ? tq.prev : cq.tail;
  assign pop      = (trd.expiry <= cur_time);
  assign em_last  = (cnt_t'(k + cnt_t'(1)) == nf);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (mode_q)
          MODE_ADD:  state_next = stored[id_q] ? S_EM_RD : S_ADD_HASH;
          MODE_DEL:  state_next = stored[id_q] ? S_DEL_T : S_EM_RD;
          MODE_TICK: state_next = S_CL_START;
          MODE_ADV:  state_next = (time_q > cur_time) ? S_CL_START : S_EM_RD;
          default:   state_next = S_EM_RD;
        endcase
      end
      S_ADD_HASH: state_next = S_PROBE;
      S_PROBE:    state_next = class_valid[pidx] ? S_PROBE_C : S_ADD_W1;
      S_PROBE_C: begin
        if (crd.ttl == ttl_q)                 state_next = S_ADD_W1;
        else if (pk == CW'(CLASS_SLOTS - 1))  state_next = S_EM_RD;
        else                                  state_next = S_PROBE;
      end
      S_ADD_W1:   state_next = S_ADD_W2;
      S_ADD_W2:   state_next = S_EM_RD;
      S_DEL_T:    state_next = S_DEL_C;
      S_DEL_C:    state_next = S_DEL_N;
      S_DEL_N:    state_next = (del_head == T_NIL) ? S_UL_P : S_EM_RD;
      S_UL_P:     state_next = S_UL_N;
      S_UL_N:     state_next = ul_ret;
      S_CL_START: state_next = (cur_time < bound) ? S_EM_RD : S_CL_CRD;
      S_CL_CRD:   state_next = (cc == C_NIL) ? S_CL_END : S_CL_C;
      S_CL_C:     state_next = (crd.head == T_NIL) ? S_CL_DONE : S_CL_T;
      S_CL_T:     state_next = (pop && trd.next != T_NIL) ? S_CL_T : S_CL_DONE;
      S_CL_DONE:  state_next = (cq.head == T_NIL) ? S_UL_P : S_CL_CRD;
      S_CL_END:   state_next = S_EM_RD;
      S_EM_RD: begin
        if (nf == '0) begin
          if (res_free) state_next = S_IDLE;
        end else begin
          state_next = S_EM_W;
        end
      end
      S_EM_W: begin
        if (res_free) state_next = em_last ? S_IDLE : S_EM_RD;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory requests and result
  always_comb begin
    treq     = '0;
    creq     = '0;
    freq     = '0;
    res_load = 1'b0;
    res      = '0;
    res.status       = status_q;
    res.live_count   = live_total;
    res.next_expiry  = bound;
    res.current_time = cur_time;
    unique case (state)
      S_DISPATCH: treq.raddr = id_q;
      S_PROBE:    creq.raddr = pidx;
      S_ADD_W1: begin
        treq.we     = 1'b1;
        treq.waddr  = id_q;
        treq.wdata  = '{expiry: add_exp, prev: cq.tail, next: T_NIL, cls: pidx};
        treq.raddr  = cq.tail[TW-1:0];
        creq.we     = 1'b1;
        creq.waddr  = pidx;
        creq.wdata  = add_cls;
        creq.raddr  = lst_head[CW-1:0];
      end
      S_ADD_W2: begin
        if (cq.tail != T_NIL) begin
          treq.we         = 1'b1;
          treq.waddr      = cq.tail[TW-1:0];
          treq.wdata      = trd;
          treq.wdata.next = {1'b0, id_q};
        end
        if (cq.head == T_NIL && lst_head != C_NIL) begin
          creq.we         = 1'b1;
          creq.waddr      = lst_head[CW-1:0];
          creq.wdata      = crd;
          creq.wdata.prev = {1'b0, pidx};
        end
      end
      S_DEL_T: begin
        creq.raddr = trd.cls;
        treq.raddr = trd.prev[TW-1:0];
      end
      S_DEL_C: begin
        if (tq.prev != T_NIL) begin
          treq.we         = 1'b1;
          treq.waddr      = tq.prev[TW-1:0];
          treq.wdata      = trd;
          treq.wdata.next = tq.next;
        end
        treq.raddr = tq.next[TW-1:0];
      end
      S_DEL_N: begin
        if (tq.next != T_NIL) begin
          treq.we         = 1'b1;
          treq.waddr      = tq.next[TW-1:0];
          treq.wdata      = trd;
          treq.wdata.prev = tq.prev;
        end
        creq.we         = 1'b1;
        creq.waddr      = tq.cls;
        creq.wdata      = cq;
        creq.wdata.head = del_head;
        creq.wdata.tail = del_tail;
        if (del_head == T_NIL) begin
          creq.wdata.prev = C_NIL;
          creq.wdata.next = C_NIL;
        end
        creq.raddr = cq.prev[CW-1:0];
      end
      S_UL_P: begin
        if (ul_pr != C_NIL) begin
          creq.we         = 1'b1;
          creq.waddr      = ul_pr[CW-1:0];
          creq.wdata      = crd;
          creq.wdata.next = ul_nx;
        end
        creq.raddr = ul_nx[CW-1:0];
      end
      S_UL_N: begin
        if (ul_nx != C_NIL) begin
          creq.we         = 1'b1;
          creq.waddr      = ul_nx[CW-1:0];
          creq.wdata      = crd;
          creq.wdata.prev = ul_pr;
        end
      end
      S_CL_CRD:   creq.raddr = cc[CW-1:0];
      S_CL_C:     treq.raddr = crd.head[TW-1:0];
      S_CL_T: begin
        if (pop) begin
          freq.we    = 1'b1;
          freq.waddr = nf[TW-1:0];
          freq.wdata = cq.head[TW-1:0];
          treq.raddr = trd.next[TW-1:0];
        end else begin
          // surviving head must carry a null prev link
          treq.we         = 1'b1;
          treq.waddr      = cq.head[TW-1:0];
          treq.wdata      = trd;
          treq.wdata.prev = T_NIL;
        end
      end
      S_CL_DONE: begin
        creq.we    = 1'b1;
        creq.waddr = cc[CW-1:0];
        creq.wdata = cq;
        if (cq.head == T_NIL) begin
          creq.wdata.tail = T_NIL;
          creq.wdata.prev = C_NIL;
          creq.wdata.next = C_NIL;
        end
        creq.raddr = cq.prev[CW-1:0];
      end
      S_EM_RD: begin
        freq.raddr = k[TW-1:0];
        if (nf == '0) begin
          res_load = res_free;
          res.last = 1'b1;
        end
      end
      S_EM_W: begin
        freq.raddr   = k[TW-1:0];
        res_load     = res_free;
        res.fired    = 1'b1;
        res.fired_id = frd;
        res.last     = em_last;
        res.status   = ST_OK;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_time    <= '0;
      live_total  <= '0;
      bound       <= TIME_MAX;
      lst_head    <= C_NIL;
      class_valid <= '0;
      stored      <= '0;
      nf          <= '0;
      k           <= '0;
      status_q    <= ST_OK;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            status_q <= ST_OK;
            nf       <= '0;
            k        <= '0;
          end
        end
        S_DISPATCH: begin
          unique case (mode_q)
            MODE_ADD:  if (stored[id_q]) status_q <= ST_DUP;
            MODE_DEL:  if (!stored[id_q]) status_q <= ST_ABSENT;
            MODE_TICK: cur_time <= cur_time + time_t'(1);
            MODE_ADV:  if (time_q > cur_time) cur_time <= time_q;
            MODE_SET:  cur_time <= time_q;
            default: ;
          endcase
        end
        S_PROBE_C: begin
          if (crd.ttl != ttl_q && pk == CW'(CLASS_SLOTS - 1)) status_q <= ST_FULL;
        end
        S_ADD_W1: begin
          stored[id_q]      <= 1'b1;
          class_valid[pidx] <= 1'b1;
          live_total        <= live_total + cnt_t'(1);
          if (add_exp < bound) bound <= add_exp;
        end
        S_ADD_W2: if (cq.head == T_NIL) lst_head <= {1'b0, pidx};
        S_DEL_N: begin
          stored[id_q] <= 1'b0;
          if (live_total != '0) live_total <= live_total - cnt_t'(1);
        end
        S_UL_P:   if (ul_pr == C_NIL) lst_head <= ul_nx;
        S_CL_T: begin
          if (pop) begin
            nf                      <= nf + cnt_t'(1);
            stored[cq.head[TW-1:0]] <= 1'b0;
          end
        end
        S_CL_END: begin
          live_total <= (live_total >= nf) ? live_total - nf : '0;
          bound      <= ne;
        end
        S_EM_W:   if (res_free) k <= k + cnt_t'(1);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mode_q <= mode_t'(in_mode);
          id_q   <= in_id;
          ttl_q  <= in_ttl;
          time_q <= in_time;
        end
      end
      S_ADD_HASH: begin
        pidx <= hash_start;
        pk   <= '0;
      end
      S_PROBE: begin
        if (!class_valid[pidx]) begin
          cq <= '{ttl: ttl_q, head: T_NIL, tail: T_NIL, prev: C_NIL, next: C_NIL};
        end
      end
      S_PROBE_C: begin
        if (crd.ttl == ttl_q) begin
          cq <= crd;
        end else begin
          pk   <= pk + CW'(1);
          pidx <= pidx + CW'(1);
        end
      end
      S_DEL_T:  tq <= trd;
      S_DEL_C:  cq <= crd;
      S_DEL_N: begin
        ul_pr  <= cq.prev;
        ul_nx  <= cq.next;
        ul_ret <= S_EM_RD;
      end
      S_CL_START: begin
        ne <= TIME_MAX;
        cc <= lst_head;
      end
      S_CL_C:   cq <= crd;
      S_CL_T: begin
        if (pop) begin
          cq.head <= trd.next;
          if (trd.next == T_NIL) cq.tail <= T_NIL;
        end else if (trd.expiry < ne) begin
          ne <= trd.expiry;
        end
      end
      S_CL_DONE: begin
        cc     <= cq.next;
        ul_pr  <= cq.prev;
        ul_nx  <= cq.next;
        ul_ret <= S_CL_CRD;
      end
      default: ;
    endcase
  end

endmodule

[rtl/ttl_bucket_timer_engine_unit.sv]
// ----------------------------------------------------------------------------
// ttl_bucket_timer_engine_unit
// TTL-bucketed timer queue engine, top level.
// ----------------------------------------------------------------------------
// One command item at a time is taken on in_ch and yields one or more result
// items on out_ch: one per fired timer in firing order, else a single plain
// item; the final item of a command has last set. Timer and class state live
// in two single-port-read RAMs (64 timer entries, 16 class entries) with a
// registered read, so every access is a read/modify/write step of a
// sequencer. Set time, ignored modes, a rejected duplicate add and a delete
// of an absent timer go straight to the result; a delete unlinks the timer
// and, when its class drains, unlinks the class from the live list; an add
// probes class slots from the hashed start, passing over occupied slots
// that hold another ttl, until it finds its ttl or a free slot or has
// passed every slot. Tick and advance skip the walk when nothing can be due
// yet; otherwise they walk every live class, pop each fired timer and
// unlink a class that drains. Fired ids are queued in a 64-entry RAM during
// the walk and sent afterward as result items. A result register sits on
// out_ch, so a new command is accepted while the last result item still
// waits to be taken.
// ----------------------------------------------------------------------------
module ttl_bucket_timer_engine_unit (
  input logic      clk,
  input logic      rst,
  ttlb_in_if.sink    in_ch,
  ttlb_out_if.source out_ch
);
  import ttlb_pkg::*;

  tmem_req_t        treq;
  timer_ent_t       trd;
  cmem_req_t        creq;
  class_ent_t       crd;
  fmem_req_t        freq;
  logic [TW-1:0]    frd;
  logic [31:0]      hash_ttl;
  logic [CW-1:0]    hash_start;
  logic             res_free;
  logic             res_load;
  res_t             res;
  res_t             out_q;
  logic             out_valid;

  // probe start hash
  ttlb_hash u_hash (
    .clk   (clk),
    .ttl   (hash_ttl),
    .start (hash_start)
  );

  // timer table: expiry, queue links, owning class
  ttlb_ram #(.WIDTH($bits(timer_ent_t)), .DEPTH(TIMER_SLOTS)) u_timer_ram (
    .clk   (clk),
    .we    (treq.we),
    .waddr (treq.waddr),
    .wdata (treq.wdata),
    .raddr (treq.raddr),
    .rdata (trd)
  );

  // class table: ttl, queue head/tail, live-list links
  ttlb_ram #(.WIDTH($bits(class_ent_t)), .DEPTH(CLASS_SLOTS)) u_class_ram (
    .clk   (clk),
    .we    (creq.we),
    .waddr (creq.waddr),
    .wdata (creq.wdata),
    .raddr (creq.raddr),
    .rdata (crd)
  );

  // fired id queue, filled by the walk and drained by result emission
  ttlb_ram #(.WIDTH(TW), .DEPTH(TIMER_SLOTS)) u_fired_ram (
    .clk   (clk),
    .we    (freq.we),
    .waddr (freq.waddr),
    .wdata (freq.wdata),
    .raddr (freq.raddr),
    .rdata (frd)
  );

  ttlb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .in_id      (in_ch.timer_id),
    .in_ttl     (in_ch.ttl),
    .in_time    (in_ch.new_time),
    .hash_ttl   (hash_ttl),
    .hash_start (hash_start),
    .treq       (treq),
    .trd        (trd),
    .creq       (creq),
    .crd        (crd),
    .freq       (freq),
    .frd        (frd),
    .res_free   (res_free),
    .res_load   (res_load),
    .res        (res)
  );

  // result register
  assign res_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.fired        = out_q.fired;
  assign out_ch.fired_id     = out_q.fired_id;
  assign out_ch.last         = out_q.last;
  assign out_ch.status       = out_q.status;
  assign out_ch.live_count   = out_q.live_count;
  assign out_ch.next_expiry  = out_q.next_expiry;
  assign out_ch.current_time = out_q.current_time;

`include "ttl_bucket_timer_engine_unit_macros.svh"

  `TTLB_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `TTLB_ASSERT_SAME(a_fired_status_ok, out_ch.valid && out_ch.fired, out_ch.status == ST_OK, "fired item with error status")
  `TTLB_ASSERT_SAME(a_live_bound, out_ch.valid, out_ch.live_count <= cnt_t'(TIMER_SLOTS), "live count above slots")

endmodule
